[src/mmth_pkg.sv]
// Shared types, constants and helpers of the multi-modulus text hash core.
`timescale 1ns / 1ps
`default_nettype none

package mmth_pkg;

	localparam int NUM_MODULI         = 4;
	localparam int MAX_MODULI         = 4;
	localparam int DIGITS_PER_RESIDUE = 6;

	localparam int CHAR_W  = 7;
	localparam int RES_W   = 30;
	localparam int BASE_W  = 9;
	localparam int ACC_W   = 38;
	localparam int REM_W   = 32;
	localparam int QUOT_W  = 9;
	localparam int LANE_W  = (NUM_MODULI > 1) ? $clog2(NUM_MODULI) : 1;
	localparam int DIGIT_W = $clog2(DIGITS_PER_RESIDUE);

	localparam logic [BASE_W-1:0] HASH_BASE = 9'd273;

	localparam logic [RES_W-1:0] PRIME [MAX_MODULI] = '{
		30'd1000000007, 30'd1000000009, 30'd1000000011, 30'd1000000017
	};

	// Quotient estimate: q ~= (acc >> EST_SHIFT) * RECIP >> RECIP_SHIFT, low by at most 2
	localparam int EST_SHIFT   = 29;
	localparam int EST_W       = ACC_W - EST_SHIFT;
	localparam int RECIP_W     = 16;
	localparam int RECIP_SHIFT = 16;
	localparam logic [RECIP_W-1:0] RECIP [MAX_MODULI] = '{
		16'((64'd1 << 45) / 64'd1000000007),
		16'((64'd1 << 45) / 64'd1000000009),
		16'((64'd1 << 45) / 64'd1000000011),
		16'((64'd1 << 45) / 64'd1000000017)
	};

	// Base 52 split as 4 * 13: low two bits pass through, the rest is divided by 13
	localparam int DIGIT_RADIX  = 52;
	localparam int LOWER_COUNT  = 26;
	localparam int RADIX_LO_W   = 2;
	localparam int RADIX_ODD    = DIGIT_RADIX >> RADIX_LO_W;
	localparam int U_W          = RES_W - RADIX_LO_W;
	localparam int ODD_SHIFT    = 32;
	localparam int ODD_RECIP_W  = 29;
	localparam logic [ODD_RECIP_W-1:0] ODD_RECIP = ODD_RECIP_W'((64'd1 << ODD_SHIFT) / RADIX_ODD);
	localparam int ODD_REM_W    = 5;
	localparam int ODD_DIG_W    = 4;
	localparam int DIG_W        = ODD_DIG_W + RADIX_LO_W;

	localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 7'd97;
	localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 7'd65;

	typedef struct packed {
		logic              action;
		logic [CHAR_W-1:0] char_code;
	} in_item_t;

	typedef struct packed {
		logic [CHAR_W-1:0] hash_char;
		logic              is_last;
	} out_item_t;

	typedef struct packed {
		logic ld_acc;
		logic ld_quot;
		logic ld_rem;
		logic wr_res;
		logic ld_val;
		logic ld_div;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic out_free;
		logic last_digit;
	} sts_t;

	function automatic logic [CHAR_W-1:0] digit_letter(input logic [DIG_W-1:0] d);
		logic [CHAR_W-1:0] dx;
		dx = CHAR_W'(d);
		if (dx < CHAR_W'(LOWER_COUNT))
			return CHAR_LOWER_A + dx;
		return CHAR_UPPER_A + dx - CHAR_W'(LOWER_COUNT);
	endfunction

endpackage

`default_nettype wire

[src/mmth_ctrl.sv]
// Sequencer of the text hash core: absorb steps and the letter emission loop.
`timescale 1ns / 1ps
`default_nettype none

module mmth_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          text_valid,
	input  wire logic          text_action,
	output logic               text_stall,
	input  wire mmth_pkg::sts_t sts,
	output mmth_pkg::cmd_t     cmd
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_EST  = 3'd1;
	localparam logic [2:0] S_RED  = 3'd2;
	localparam logic [2:0] S_FIX  = 3'd3;
	localparam logic [2:0] S_DIV  = 3'd4;
	localparam logic [2:0] S_EMIT = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_nxt;
	logic       accept;

	assign text_stall = (state_q != S_IDLE);
	assign accept     = text_valid && (state_q == S_IDLE);

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (text_action) begin
						cmd.ld_val = 1'b1;
						state_nxt  = S_DIV;
					end else begin
						cmd.ld_acc = 1'b1;
						state_nxt  = S_EST;
					end
				end
			end
			S_EST: begin
				cmd.ld_quot = 1'b1;
				state_nxt   = S_RED;
			end
			S_RED: begin
				cmd.ld_rem = 1'b1;
				state_nxt  = S_FIX;
			end
			S_FIX: begin
				cmd.wr_res = 1'b1;
				state_nxt  = S_IDLE;
			end
			S_DIV: begin
				cmd.ld_div = 1'b1;
				state_nxt  = S_EMIT;
			end
			S_EMIT: begin
				// hold until the output register can take the letter
				if (sts.out_free) begin
					cmd.emit  = 1'b1;
					state_nxt = sts.last_digit ? S_IDLE : S_DIV;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

`default_nettype wire

[src/mmth_dp.sv]
// Datapath of the text hash core: residue lanes, base-52 digit unit, output register.
`timescale 1ns / 1ps
`default_nettype none

module mmth_dp (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic [mmth_pkg::CHAR_W-1:0]   char_code,
	input  wire mmth_pkg::cmd_t                cmd,
	output mmth_pkg::sts_t                     sts,
	output logic                               hash_valid,
	input  wire logic                          hash_stall,
	output mmth_pkg::out_item_t                hash_item
);

	localparam int NM = mmth_pkg::NUM_MODULI;
	localparam int RW = mmth_pkg::RES_W;
	localparam int AW = mmth_pkg::ACC_W;
	localparam int UW = mmth_pkg::U_W;
	localparam int LW = mmth_pkg::LANE_W;
	localparam int DW = mmth_pkg::DIGIT_W;

	logic [RW-1:0] residues_q [NM];

	logic [LW-1:0] lane_q;
	logic [DW-1:0] digit_q;
	logic [RW-1:0] val_q;
	logic [UW-1:0] quot_d_s1;

	logic          last_lane;
	logic          last_in_lane;
	logic          lane_done;

	mmth_pkg::out_item_t out_q;
	logic                out_valid_q;

	// ---------------- absorb lanes ----------------
	for (genvar m = 0; m < NM; m++) begin : g_lane
		logic [AW-1:0]                                       acc_s1;
		logic [AW-1:0]                                       acc_s2;
		logic [mmth_pkg::QUOT_W-1:0]                         quot_s2;
		logic [mmth_pkg::REM_W-1:0]                          rem_s3;
		logic [mmth_pkg::EST_W+mmth_pkg::RECIP_W-1:0]        est_prod;
		logic [mmth_pkg::REM_W-1:0]                          p1;
		logic [mmth_pkg::REM_W-1:0]                          p2;
		logic [RW-1:0]                                       res_fix;

		assign est_prod = (mmth_pkg::EST_W + mmth_pkg::RECIP_W)'(
			acc_s1[AW-1:mmth_pkg::EST_SHIFT]) *
			(mmth_pkg::EST_W + mmth_pkg::RECIP_W)'(mmth_pkg::RECIP[m]);

		assign p1 = mmth_pkg::REM_W'(mmth_pkg::PRIME[m]);
		assign p2 = p1 << 1;

		// the estimate is low by at most two moduli
		always_comb begin
			if (rem_s3 >= p2)
				res_fix = RW'(rem_s3 - p2);
			else if (rem_s3 >= p1)
				res_fix = RW'(rem_s3 - p1);
			else
				res_fix = RW'(rem_s3);
		end

		always_ff @(posedge clk) begin
			if (cmd.ld_acc)
				acc_s1 <= AW'(residues_q[m]) * AW'(mmth_pkg::HASH_BASE) + AW'(char_code);
			if (cmd.ld_quot) begin
				acc_s2  <= acc_s1;
				quot_s2 <= est_prod[mmth_pkg::RECIP_SHIFT +: mmth_pkg::QUOT_W];
			end
			if (cmd.ld_rem)
				rem_s3 <= mmth_pkg::REM_W'(acc_s2 - AW'(quot_s2) * AW'(mmth_pkg::PRIME[m]));
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				residues_q[m] <= '0;
			end else if (cmd.wr_res) begin
				residues_q[m] <= res_fix;
			end else if (cmd.emit && lane_done && (lane_q == LW'(m))) begin
				residues_q[m] <= '0;
			end
		end
	end

	// ---------------- digit unit ----------------
	logic [UW-1:0]                                   u_val;
	logic [mmth_pkg::ODD_SHIFT+UW-1:0]               odd_prod;
	logic [UW-1:0]                                   rem_full;
	logic [mmth_pkg::ODD_REM_W-1:0]                  rem_small;
	logic [UW-1:0]                                   quot_adj;
	logic [mmth_pkg::ODD_DIG_W-1:0]                  odd_dig;
	logic [mmth_pkg::DIG_W-1:0]                      digit;
	logic [LW-1:0]                                   lane_nxt;

	assign u_val    = val_q[RW-1:mmth_pkg::RADIX_LO_W];
	assign odd_prod = (mmth_pkg::ODD_SHIFT + UW)'(u_val) *
		(mmth_pkg::ODD_SHIFT + UW)'(mmth_pkg::ODD_RECIP);
	assign rem_full  = u_val - quot_d_s1 * UW'(mmth_pkg::RADIX_ODD);
	assign rem_small = rem_full[mmth_pkg::ODD_REM_W-1:0];

	// the quotient estimate is low by at most one
	always_comb begin
		if (rem_small >= mmth_pkg::ODD_REM_W'(mmth_pkg::RADIX_ODD)) begin
			quot_adj = quot_d_s1 + UW'(1);
			odd_dig  = mmth_pkg::ODD_DIG_W'(rem_small - mmth_pkg::ODD_REM_W'(mmth_pkg::RADIX_ODD));
		end else begin
			quot_adj = quot_d_s1;
			odd_dig  = mmth_pkg::ODD_DIG_W'(rem_small);
		end
	end

	assign digit        = {odd_dig, val_q[mmth_pkg::RADIX_LO_W-1:0]};
	assign last_lane    = (lane_q == LW'(NM - 1));
	assign last_in_lane = (digit_q == DW'(mmth_pkg::DIGITS_PER_RESIDUE - 1));
	assign lane_done    = last_in_lane;
	assign lane_nxt     = lane_q + LW'(1);

	always_ff @(posedge clk) begin
		if (cmd.ld_div)
			quot_d_s1 <= odd_prod[mmth_pkg::ODD_SHIFT +: UW];
		if (cmd.ld_val) begin
			val_q <= residues_q[0];
		end else if (cmd.emit) begin
			if (!last_in_lane)
				val_q <= RW'(quot_adj);
			else if (!last_lane)
				val_q <= residues_q[lane_nxt];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lane_q  <= '0;
			digit_q <= '0;
		end else if (cmd.ld_val) begin
			lane_q  <= '0;
			digit_q <= '0;
		end else if (cmd.emit) begin
			if (last_in_lane) begin
				digit_q <= '0;
				lane_q  <= last_lane ? '0 : lane_nxt;
			end else begin
				digit_q <= digit_q + DW'(1);
			end
		end
	end

	// ---------------- output register ----------------
	assign sts.out_free   = !out_valid_q || !hash_stall;
	assign sts.last_digit = last_lane && last_in_lane;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (!hash_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_q.hash_char <= mmth_pkg::digit_letter(digit);
			out_q.is_last   <= last_lane && last_in_lane;
		end
	end

	assign hash_valid = out_valid_q;
	assign hash_item  = out_q;

endmodule

`default_nettype wire

[src/multi_modulus_text_hash_core.sv]
// Top level of the multi-modulus text hash core.
//
//  channel | dir | handshake                 | payload
//  text    | in  | text_valid / text_stall   | text_item (action, char_code)
//  hash    | out | hash_valid / hash_stall   | hash_item (hash_char, is_last)
//
// A character item runs the residue update through a multiply, a reciprocal
// quotient estimate, a multiply-subtract and a final correction.
// A finish item emits 24 letters, each through the digit unit's estimate and
// correction steps; hash_stall holds each letter back until the output is free.
// Reset clears all residues to zero; no clearing pass is needed.
// The last letter sits in the output register while the next item is accepted.
`timescale 1ns / 1ps
`default_nettype none

module multi_modulus_text_hash_core (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          text_valid,
	output logic               text_stall,
	input  wire mmth_pkg::in_item_t text_item,
	output logic               hash_valid,
	input  wire logic          hash_stall,
	output mmth_pkg::out_item_t hash_item
);

	mmth_pkg::cmd_t cmd;
	mmth_pkg::sts_t sts;

	mmth_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.text_valid  (text_valid),
		.text_action (text_item.action),
		.text_stall  (text_stall),
		.sts         (sts),
		.cmd         (cmd)
	);

	mmth_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.char_code  (text_item.char_code),
		.cmd        (cmd),
		.sts        (sts),
		.hash_valid (hash_valid),
		.hash_stall (hash_stall),
		.hash_item  (hash_item)
	);

endmodule

`default_nettype wire

[tb/multi_modulus_text_hash_core_tb.sv]
// Self-checking testbench for the multi-modulus text hash core.
`timescale 1ns / 1ps

module multi_modulus_text_hash_core_tb;

	localparam int N_ITEMS      = 330;
	localparam int QUIET_AFTER  = 280;
	localparam int LONG_HOLD    = 300;
	localparam int DRAIN_CYCLES = 60;
	localparam int LETTERS      = mmth_pkg::NUM_MODULI * mmth_pkg::DIGITS_PER_RESIDUE;

	localparam logic ACT_ABSORB = 1'b0;
	localparam logic ACT_FINISH = 1'b1;

	// Running residues of the current text and the letters its finish must produce
	class hash_scoreboard;
		localparam logic [63:0] MODULUS [4] = '{
			64'd1000000007, 64'd1000000009, 64'd1000000011, 64'd1000000017
		};
		logic [mmth_pkg::RES_W-1:0] residue [4];
		mmth_pkg::out_item_t letters_due [$];

		function new();
			foreach (residue[m])
				residue[m] = '0;
		endfunction

		function void note_text(mmth_pkg::in_item_t it);
			logic [63:0] acc;
			logic [63:0] v;
			logic [5:0] d;
			mmth_pkg::out_item_t letter;
			int idx;
			if (it.action == ACT_ABSORB) begin
				for (int m = 0; m < mmth_pkg::NUM_MODULI; m++) begin
					acc = 64'(residue[m]) * 64'd273 + 64'(it.char_code);
					residue[m] = mmth_pkg::RES_W'(acc % MODULUS[m]);
				end
				return;
			end
			idx = 0;
			for (int m = 0; m < mmth_pkg::NUM_MODULI; m++) begin
				v = 64'(residue[m]);
				for (int k = 0; k < mmth_pkg::DIGITS_PER_RESIDUE; k++) begin
					d = 6'(v % 64'd52);
					v = v / 64'd52;
					letter.hash_char = (d < 6'd26) ? mmth_pkg::CHAR_W'(7'd97 + d) :
						mmth_pkg::CHAR_W'(7'd65 + d - 6'd26);
					letter.is_last = (idx == LETTERS - 1);
					letters_due.push_back(letter);
					idx++;
				end
				residue[m] = '0;
			end
		endfunction

		// Empty string when the letter matches the oldest one due
		function string check_letter(mmth_pkg::out_item_t got);
			mmth_pkg::out_item_t want;
			string msg;
			if (letters_due.size() == 0)
				return $sformatf("letter '%c' is_last=%0b with nothing due",
					got.hash_char, got.is_last);
			want = letters_due.pop_front();
			msg = "";
			if (got.hash_char !== want.hash_char)
				msg = {msg, $sformatf(" hash_char got %0d want %0d;", got.hash_char,
					want.hash_char)};
			if (got.is_last !== want.is_last)
				msg = {msg, $sformatf(" is_last got %0b want %0b;", got.is_last, want.is_last)};
			return msg;
		endfunction

		function int pending();
			return letters_due.size();
		endfunction
	endclass

	logic                clk;
	logic                arst_n;
	logic                text_valid;
	logic                text_stall;
	mmth_pkg::in_item_t  text_item;
	logic                hash_valid;
	logic                hash_stall;
	mmth_pkg::out_item_t hash_item;

	hash_scoreboard sb;
	int  mismatches;
	int  items_sent;
	int  finishes_sent;
	int  letters_seen;
	bit  quiet;
	bit  hold_req;

	multi_modulus_text_hash_core dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.text_valid (text_valid),
		.text_stall (text_stall),
		.text_item  (text_item),
		.hash_valid (hash_valid),
		.hash_stall (hash_stall),
		.hash_item  (hash_item)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	task automatic report(string msg);
		mismatches++;
		$display("[%0t] MISMATCH:%s", $realtime, msg);
	endtask

	// Offer one item, with a random idle burst ahead of it, and hold it until taken
	task automatic send_item(logic act, logic [mmth_pkg::CHAR_W-1:0] ch);
		mmth_pkg::in_item_t it;
		it.action = act;
		it.char_code = ch;
		if (!quiet && $urandom_range(0, 3) == 0) begin
			repeat ($urandom_range(1, 6)) begin
				@(negedge clk);
				text_valid <= 1'b0;
			end
		end
		@(negedge clk);
		text_valid <= 1'b1;
		text_item <= it;
		do
			@(posedge clk);
		while (text_stall);
		sb.note_text(it);
		items_sent++;
		if (act == ACT_FINISH)
			finishes_sent++;
		if (items_sent >= QUIET_AFTER)
			quiet = 1'b1;
	endtask

	task automatic send_text(int len);
		repeat (len)
			send_item(ACT_ABSORB, mmth_pkg::CHAR_W'($urandom_range(0, 127)));
		send_item(ACT_FINISH, mmth_pkg::CHAR_W'($urandom_range(0, 127)));
	endtask

	// Receiver: random stall bursts, plus one long hold-off on request
	initial begin
		hash_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hash_stall <= 1'b1;
				repeat (LONG_HOLD) @(negedge clk);
				hold_req = 1'b0;
				hash_stall <= 1'b0;
			end else if (!quiet && $urandom_range(0, 3) == 0) begin
				hash_stall <= 1'b1;
				repeat ($urandom_range(1, 6) - 1) @(negedge clk);
			end else begin
				hash_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		string msg;
		if (arst_n && hash_valid === 1'b1 && hash_stall == 1'b0) begin
			letters_seen++;
			msg = sb.check_letter(hash_item);
			if (msg != "")
				report(msg);
		end
	end

	initial begin
		#5ms;
		$display("timeout with %0d letters still due", sb.pending());
		$display("end of test: mismatches");
		$finish;
	end

	initial begin
		int len;
		sb = new();
		mismatches = 0;
		items_sent = 0;
		finishes_sent = 0;
		letters_seen = 0;
		quiet = 1'b0;
		hold_req = 1'b0;
		arst_n = 1'b0;
		text_valid = 1'b0;
		text_item = '0;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;

		// Empty text right after reset, finish char ignored; then empty again
		send_item(ACT_FINISH, 7'h7F);
		send_item(ACT_FINISH, 7'h00);
		// Single zero character hashes to zero
		send_item(ACT_ABSORB, 7'h00);
		send_item(ACT_FINISH, 7'h55);
		// Top character code, long enough to wrap every modulus
		repeat (6) send_item(ACT_ABSORB, 7'h7F);
		send_item(ACT_FINISH, 7'h2A);
		// Alternating bit patterns
		send_item(ACT_ABSORB, 7'h55);
		send_item(ACT_ABSORB, 7'h2A);
		send_item(ACT_ABSORB, 7'h01);
		send_item(ACT_ABSORB, 7'h40);
		send_item(ACT_FINISH, 7'h00);
		// Single top character
		send_item(ACT_ABSORB, 7'h7F);
		send_item(ACT_FINISH, 7'h7F);

		// Block the output while texts keep coming so the core backs up
		hold_req = 1'b1;
		while (items_sent < N_ITEMS) begin
			case ($urandom_range(0, 9))
				0:       len = 0;
				1:       len = $urandom_range(20, 60);
				default: len = $urandom_range(1, 12);
			endcase
			// keep the last text inside the item budget
			if (len > N_ITEMS - items_sent - 1)
				len = N_ITEMS - items_sent - 1;
			send_text(len);
		end

		@(negedge clk);
		text_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("ran %0d text items with %0d finishes, %0d hash letters checked",
			items_sent, finishes_sent, letters_seen);
		$display("output held off for %0d cycles once, idle bursts on both sides",
			LONG_HOLD);
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
